// ===== hw/rtl/target_frame_parser_with_timeout_macros.svh =====
// assertion macros for the target frame parser
`ifndef TARGET_FRAME_PARSER_WITH_TIMEOUT_MACROS_SVH
`define TARGET_FRAME_PARSER_WITH_TIMEOUT_MACROS_SVH

// same-cycle property, clocked on i_clk, off during reset
`define TFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// next-cycle implication
`define TFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    `TFP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/tfp_pkg.sv =====
`timescale 1ns / 1ps
package tfp_pkg;

    localparam int FRAME_BUF_BYTES_DEF = 32;
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;
    localparam int EV_W = 3;
    localparam int CLS_W = 3;
    localparam int HELD_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW = 1;

    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_VALID    = 3'd1;
    localparam logic [EV_W-1:0] EV_FORMAT   = 3'd2;
    localparam logic [EV_W-1:0] EV_RANGE    = 3'd3;
    localparam logic [EV_W-1:0] EV_OVERFLOW = 3'd4;

    localparam logic [HELD_W-1:0] HELD_NONE   = 2'd0;
    localparam logic [HELD_W-1:0] HELD_FORMAT = 2'd1;
    localparam logic [HELD_W-1:0] HELD_RANGE  = 2'd2;

    localparam logic [CLS_W-1:0] CL_TICK   = 3'd0;
    localparam logic [CLS_W-1:0] CL_DOLLAR = 3'd1;
    localparam logic [CLS_W-1:0] CL_HASH   = 3'd2;
    localparam logic [CLS_W-1:0] CL_BAD    = 3'd3;
    localparam logic [CLS_W-1:0] CL_DIGIT  = 3'd4;
    localparam logic [CLS_W-1:0] CL_COMMA  = 3'd5;
    localparam logic [CLS_W-1:0] CL_OTHER  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX   = 2'd2;

    localparam logic [DATA_W-1:0] TIMEOUT_RST = 16'd100;
    localparam logic [DATA_W-1:0] X_MAX_RST   = 16'd639;
    localparam logic [DATA_W-1:0] Y_MAX_RST   = 16'd479;
    localparam logic [DATA_W-1:0] AGE_SAT     = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_DOLLAR   = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HASH     = 8'h23;
    localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [DATA_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] timeout_ms;
        logic [DATA_W-1:0] x_max;
        logic [DATA_W-1:0] y_max;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic              online;
        logic              has_target;
        logic [DATA_W-1:0] target_x;
        logic [DATA_W-1:0] target_y;
        logic [DATA_W-1:0] age_ms;
    } t_result;

endpackage

// ===== hw/rtl/tfp_queue.sv =====
`timescale 1ns / 1ps
module tfp_queue import tfp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);
    localparam logic [Q_AW:0]   CNT_FULL = (Q_AW + 1)'(Q_DEPTH);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tfp_front.sv =====
`timescale 1ns / 1ps
module tfp_front import tfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [DATA_W-1:0] i_elapsed_ms,
    output logic              o_item_valid,
    input  logic              i_item_ready,
    output t_item             o_item
);

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [3:0]        digit;

    // ascii digits carry their value in the low nibble
    assign digit = i_rx_byte[3:0];

    always_comb begin
        n_item.data = {{(DATA_W - BYTE_W){1'b0}}, i_rx_byte};
        if (i_kind) begin
            n_item.cls  = CL_TICK;
            n_item.data = i_elapsed_ms;
        end else if (i_rx_byte == CH_DOLLAR) begin
            n_item.cls = CL_DOLLAR;
        end else if (i_rx_byte == CH_HASH) begin
            n_item.cls = CL_HASH;
        end else if (i_rx_byte < CH_PRINT_LO || i_rx_byte > CH_PRINT_HI) begin
            n_item.cls = CL_BAD;
        end else if (i_rx_byte >= CH_ZERO && i_rx_byte <= CH_NINE) begin
            n_item.cls  = CL_DIGIT;
            n_item.data = {{(DATA_W - 4){1'b0}}, digit};
        end else if (i_rx_byte == CH_COMMA) begin
            n_item.cls = CL_COMMA;
        end else begin
            n_item.cls = CL_OTHER;
        end
    end

    assign o_in_ready   = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/tfp_back.sv =====
`timescale 1ns / 1ps
module tfp_back import tfp_pkg::*; #(
    parameter int FRAME_BUF_BYTES = FRAME_BUF_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_item   i_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    localparam int CNT_W = $clog2(FRAME_BUF_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BUF_BYTES - 1);
    localparam int MUL_W = DATA_W + 4;

    logic              r_in_frame,        n_in_frame;
    logic [CNT_W-1:0]  r_char_count,      n_char_count;
    logic [1:0]        r_field_pos,       n_field_pos;
    logic [DATA_W-1:0] r_field_acc,       n_field_acc;
    logic              r_field_has_digit, n_field_has_digit;
    logic [HELD_W-1:0] r_held,            n_held;
    logic              r_parsed_flag,     n_parsed_flag;
    logic [DATA_W-1:0] r_parsed_x,        n_parsed_x;
    logic [DATA_W-1:0] r_latched_x,       n_latched_x;
    logic [DATA_W-1:0] r_latched_y,       n_latched_y;
    logic              r_latched_valid,   n_latched_valid;
    logic [DATA_W-1:0] r_age,             n_age;
    logic              r_seen,            n_seen;
    logic              r_out_valid;
    t_result           r_result,          n_result;

    logic              take;
    logic              clr;
    logic              clr_open;
    logic [HELD_W-1:0] empty_err;
    logic [HELD_W-1:0] fe_err;
    logic [DATA_W-1:0] lim;
    logic [MUL_W-1:0]  acc_ext;
    logic [MUL_W-1:0]  acc_next;
    logic [DATA_W:0]   age_sum;
    logic [DATA_W-1:0] tick_age;
    logic              online;
    logic              target;

    assign o_item_ready = !r_out_valid || i_out_ready;
    assign take         = i_item_valid && o_item_ready;
    assign o_out_valid  = r_out_valid;
    assign o_result     = r_result;

    assign empty_err = (r_field_pos == 2'd0) ? HELD_FORMAT : HELD_RANGE;
    assign lim       = (r_field_pos == 2'd0) ? DATA_W'(1) :
                       (r_field_pos == 2'd1) ? i_cfg.x_max : i_cfg.y_max;
    assign acc_ext   = {4'b0, r_field_acc};
    assign acc_next  = (acc_ext << 3) + (acc_ext << 1) + {{(MUL_W - 4){1'b0}}, i_item.data[3:0]};
    assign age_sum   = {1'b0, r_age} + {1'b0, i_item.data};
    assign tick_age  = age_sum[DATA_W] ? AGE_SAT : age_sum[DATA_W-1:0];

    // error reported at frame end
    always_comb begin
        fe_err = r_held;
        if (r_held == HELD_NONE) begin
            if (!r_field_has_digit) begin
                fe_err = empty_err;
            end else if (r_field_pos < 2'd2) begin
                fe_err = HELD_FORMAT;
            end else if (!r_parsed_flag && (r_parsed_x != '0 || r_field_acc != '0)) begin
                fe_err = HELD_FORMAT;
            end
        end
    end

    always_comb begin
        n_in_frame        = r_in_frame;
        n_char_count      = r_char_count;
        n_field_pos       = r_field_pos;
        n_field_acc       = r_field_acc;
        n_field_has_digit = r_field_has_digit;
        n_held            = r_held;
        n_parsed_flag     = r_parsed_flag;
        n_parsed_x        = r_parsed_x;
        n_latched_x       = r_latched_x;
        n_latched_y       = r_latched_y;
        n_latched_valid   = r_latched_valid;
        n_age             = r_age;
        n_seen            = r_seen;
        n_result.event_res = EV_NONE;
        clr               = 1'b0;
        clr_open          = 1'b0;

        if (i_item.cls == CL_TICK) begin
            n_age = tick_age;
            if (tick_age > i_cfg.timeout_ms) begin
                n_latched_valid = 1'b0;
                n_latched_x     = '0;
                n_latched_y     = '0;
            end
        end else if (i_item.cls == CL_DOLLAR) begin
            clr      = 1'b1;
            clr_open = 1'b1;
        end else if (r_in_frame) begin
            unique case (i_item.cls)
                CL_HASH: begin
                    clr = 1'b1;
                    if (r_char_count == '0 || fe_err == HELD_FORMAT) begin
                        n_result.event_res = EV_FORMAT;
                    end else if (fe_err == HELD_RANGE) begin
                        n_result.event_res = EV_RANGE;
                    end else begin
                        n_result.event_res = EV_VALID;
                        n_latched_valid    = r_parsed_flag;
                        n_latched_x        = r_parsed_flag ? r_parsed_x : '0;
                        n_latched_y        = r_parsed_flag ? r_field_acc : '0;
                        n_age              = '0;
                        n_seen             = 1'b1;
                    end
                end
                CL_BAD: begin
                    clr                = 1'b1;
                    n_result.event_res = EV_FORMAT;
                end
                default: begin
                    if (r_char_count == CNT_LAST) begin
                        clr                = 1'b1;
                        n_result.event_res = EV_OVERFLOW;
                    end else begin
                        n_char_count = r_char_count + 1'b1;
                        if (r_held == HELD_NONE) begin
                            if (i_item.cls == CL_DIGIT) begin
                                if (acc_next > {4'b0, lim}) begin
                                    n_held = empty_err;
                                end else begin
                                    n_field_acc       = acc_next[DATA_W-1:0];
                                    n_field_has_digit = 1'b1;
                                end
                            end else if (!r_field_has_digit) begin
                                n_held = empty_err;
                            end else if (r_field_pos < 2'd2 && i_item.cls == CL_COMMA) begin
                                if (r_field_pos == 2'd0) begin
                                    n_parsed_flag = r_field_acc[0];
                                end else begin
                                    n_parsed_x = r_field_acc;
                                end
                                n_field_pos       = r_field_pos + 1'b1;
                                n_field_acc       = '0;
                                n_field_has_digit = 1'b0;
                            end else begin
                                n_held = HELD_FORMAT;
                            end
                        end
                    end
                end
            endcase
        end

        if (clr) begin
            n_in_frame        = clr_open;
            n_char_count      = '0;
            n_field_pos       = 2'd0;
            n_field_acc       = '0;
            n_field_has_digit = 1'b0;
            n_held            = HELD_NONE;
        end

        online = n_seen && (n_age <= i_cfg.timeout_ms);
        target = online && n_latched_valid;
        n_result.online     = online;
        n_result.has_target = target;
        n_result.target_x   = target ? n_latched_x : '0;
        n_result.target_y   = target ? n_latched_y : '0;
        n_result.age_ms     = n_age;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame        <= 1'b0;
            r_char_count      <= '0;
            r_field_pos       <= 2'd0;
            r_field_acc       <= '0;
            r_field_has_digit <= 1'b0;
            r_held            <= HELD_NONE;
            r_parsed_flag     <= 1'b0;
            r_parsed_x        <= '0;
            r_latched_x       <= '0;
            r_latched_y       <= '0;
            r_latched_valid   <= 1'b0;
            r_age             <= AGE_SAT;
            r_seen            <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (take) begin
                r_in_frame        <= n_in_frame;
                r_char_count      <= n_char_count;
                r_field_pos       <= n_field_pos;
                r_field_acc       <= n_field_acc;
                r_field_has_digit <= n_field_has_digit;
                r_held            <= n_held;
                r_parsed_flag     <= n_parsed_flag;
                r_parsed_x        <= n_parsed_x;
                r_latched_x       <= n_latched_x;
                r_latched_y       <= n_latched_y;
                r_latched_valid   <= n_latched_valid;
                r_age             <= n_age;
                r_seen            <= n_seen;
                r_out_valid       <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/target_frame_parser_with_timeout.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   i_kind, i_rx_byte, i_elapsed_ms
// out      output     o_out_valid / i_out_ready o_event_res, o_online, o_has_target,
//                                               o_target_x, o_target_y, o_age_ms
// cfg      input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; an accepted item passes through
// the classify register, the two-entry queue and the execute/output register, in that order
// the frame parser and age counter update once per accepted item in the back end
// reset is synchronous and active low; no clearing pass
// an output stall fills the output register, then the queue, then the front register
module target_frame_parser_with_timeout import tfp_pkg::*; #(
    parameter int FRAME_BUF_BYTES = FRAME_BUF_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic [DATA_W-1:0]    i_elapsed_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [EV_W-1:0]      o_event_res,
    output logic                 o_online,
    output logic                 o_has_target,
    output logic [DATA_W-1:0]    o_target_x,
    output logic [DATA_W-1:0]    o_target_y,
    output logic [DATA_W-1:0]    o_age_ms,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    logic    front_valid;
    logic    front_ready;
    t_item   front_item;
    logic    q_valid;
    logic    q_ready;
    t_item   q_item;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms <= TIMEOUT_RST;
            r_cfg.x_max      <= X_MAX_RST;
            r_cfg.y_max      <= Y_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIMEOUT: r_cfg.timeout_ms <= i_cfg_data;
                REG_X_MAX:   r_cfg.x_max      <= i_cfg_data;
                REG_Y_MAX:   r_cfg.y_max      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .i_elapsed_ms (i_elapsed_ms),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    tfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    tfp_back #(
        .FRAME_BUF_BYTES (FRAME_BUF_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_event_res  = result.event_res;
    assign o_online     = result.online;
    assign o_has_target = result.has_target;
    assign o_target_x   = result.target_x;
    assign o_target_y   = result.target_y;
    assign o_age_ms     = result.age_ms;

endmodule

// ===== hw/rtl/tfp_checker.sv =====
`timescale 1ns / 1ps
`include "target_frame_parser_with_timeout_macros.svh"
module tfp_checker import tfp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [EV_W-1:0]   o_event_res,
    input logic              o_online,
    input logic              o_has_target,
    input logic [DATA_W-1:0] o_target_x,
    input logic [DATA_W-1:0] o_target_y,
    input logic [DATA_W-1:0] o_age_ms
);

    `TFP_ASSERT(a_target_needs_online, o_out_valid && o_has_target |-> o_online, "target without link")
    `TFP_ASSERT(a_no_target_zero, o_out_valid && !o_has_target |-> o_target_x == '0 && o_target_y == '0, "stale coordinates")
    `TFP_ASSERT(a_valid_frame_fresh, o_out_valid && o_event_res == EV_VALID |-> o_age_ms == '0 && o_online, "valid frame did not reset age")
    `TFP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_event_res) && $stable(o_age_ms), "stalled result changed")

endmodule

bind target_frame_parser_with_timeout tfp_checker u_tfp_checker (.*);

// ===== tb/tb_target_frame_parser_with_timeout.sv =====
`timescale 1ns / 1ps
module tb_target_frame_parser_with_timeout;
    import tfp_pkg::*;

    localparam int BODY_MAX = FRAME_BUF_BYTES_DEF - 1;
    localparam int TAIL_CYCLES = 8;

    class link_scoreboard;
        logic [DATA_W-1:0] timeout_ms;
        logic [DATA_W-1:0] x_max;
        logic [DATA_W-1:0] y_max;

        bit                in_frame;
        bit [4:0]          char_count;
        bit [1:0]          field_pos;
        logic [DATA_W-1:0] field_acc;
        bit                field_has_digit;
        logic [HELD_W-1:0] held;
        bit                parsed_flag;
        logic [DATA_W-1:0] parsed_x;
        logic [DATA_W-1:0] latched_x;
        logic [DATA_W-1:0] latched_y;
        bit                latched_valid;
        logic [DATA_W-1:0] age;
        bit                seen_frame;

        t_result status_q[$];
        int errors;

        function new();
            timeout_ms = TIMEOUT_RST;
            x_max = X_MAX_RST;
            y_max = Y_MAX_RST;
            restart(1'b0);
            parsed_flag = 1'b0;
            parsed_x = '0;
            latched_x = '0;
            latched_y = '0;
            latched_valid = 1'b0;
            age = AGE_SAT;
            seen_frame = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_TIMEOUT: timeout_ms = val;
                REG_X_MAX: x_max = val;
                REG_Y_MAX: y_max = val;
                default: ;
            endcase
        endfunction

        function void restart(bit open);
            in_frame = open;
            char_count = '0;
            field_pos = '0;
            field_acc = '0;
            field_has_digit = 1'b0;
            held = HELD_NONE;
        endfunction

        function logic [HELD_W-1:0] empty_code();
            return (field_pos == 0) ? HELD_FORMAT : HELD_RANGE;
        endfunction

        function void absorb_char(logic [BYTE_W-1:0] c);
            int unsigned lim;
            int unsigned v;
            if (held != HELD_NONE) return;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                lim = (field_pos == 0) ? 1 : ((field_pos == 1) ? x_max : y_max);
                v = int'(field_acc) * 10 + int'(c - CH_ZERO);
                if (v > lim) begin
                    held = empty_code();
                end else begin
                    field_acc = v[DATA_W-1:0];
                    field_has_digit = 1'b1;
                end
            end else if (!field_has_digit) begin
                held = empty_code();
            end else if (field_pos < 2 && c == CH_COMMA) begin
                if (field_pos == 0) begin
                    parsed_flag = field_acc[0];
                end else begin
                    parsed_x = field_acc;
                end
                field_pos = field_pos + 1'b1;
                field_acc = '0;
                field_has_digit = 1'b0;
            end else begin
                held = HELD_FORMAT;
            end
        endfunction

        function logic [EV_W-1:0] finish_frame();
            logic [HELD_W-1:0] err;
            err = held;
            if (err == HELD_NONE) begin
                if (!field_has_digit) begin
                    err = empty_code();
                end else if (field_pos < 2) begin
                    err = HELD_FORMAT;
                end else if (!parsed_flag && (parsed_x != 0 || field_acc != 0)) begin
                    err = HELD_FORMAT;
                end
            end
            if (err == HELD_FORMAT) return EV_FORMAT;
            if (err == HELD_RANGE) return EV_RANGE;
            if (parsed_flag) begin
                latched_x = parsed_x;
                latched_y = field_acc;
                latched_valid = 1'b1;
            end else begin
                latched_x = '0;
                latched_y = '0;
                latched_valid = 1'b0;
            end
            age = '0;
            seen_frame = 1'b1;
            return EV_VALID;
        endfunction

        function logic [EV_W-1:0] parse_byte(logic [BYTE_W-1:0] b);
            logic [EV_W-1:0] ev;
            if (b == CH_DOLLAR) begin
                restart(1'b1);
                return EV_NONE;
            end
            if (!in_frame) return EV_NONE;
            if (b == CH_HASH) begin
                ev = (char_count == 0) ? EV_FORMAT : finish_frame();
                restart(1'b0);
                return ev;
            end
            if (b < CH_PRINT_LO || b > CH_PRINT_HI) begin
                restart(1'b0);
                return EV_FORMAT;
            end
            if (char_count >= BODY_MAX) begin
                restart(1'b0);
                return EV_OVERFLOW;
            end
            char_count = char_count + 1'b1;
            absorb_char(b);
            return EV_NONE;
        endfunction

        function void age_by(logic [DATA_W-1:0] ms);
            int unsigned sum;
            sum = int'(age) + int'(ms);
            age = (sum > AGE_SAT) ? AGE_SAT : sum[DATA_W-1:0];
            if (age > timeout_ms) begin
                latched_valid = 1'b0;
                latched_x = '0;
                latched_y = '0;
            end
        endfunction

        function void take_item(logic kind, logic [BYTE_W-1:0] b, logic [DATA_W-1:0] ms);
            t_result r;
            bit up;
            bit tgt;
            r.event_res = EV_NONE;
            if (!kind) begin
                r.event_res = parse_byte(b);
            end else begin
                age_by(ms);
            end
            up = seen_frame && (age <= timeout_ms);
            tgt = up && latched_valid;
            r.online = up;
            r.has_target = tgt;
            r.target_x = tgt ? latched_x : '0;
            r.target_y = tgt ? latched_y : '0;
            r.age_ms = age;
            status_q.push_back(r);
        endfunction

        function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(t_result got);
            t_result want;
            if (status_q.size() == 0) begin
                $error("result with no item pending");
                errors++;
                return;
            end
            want = status_q.pop_front();
            check_field("event_res", want.event_res, got.event_res);
            check_field("online", want.online, got.online);
            check_field("has_target", want.has_target, got.has_target);
            check_field("target_x", want.target_x, got.target_x);
            check_field("target_y", want.target_y, got.target_y);
            check_field("age_ms", want.age_ms, got.age_ms);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_kind;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic [DATA_W-1:0]    i_elapsed_ms;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [EV_W-1:0]      o_event_res;
    logic                 o_online;
    logic                 o_has_target;
    logic [DATA_W-1:0]    o_target_x;
    logic [DATA_W-1:0]    o_target_y;
    logic [DATA_W-1:0]    o_age_ms;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    link_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;

    target_frame_parser_with_timeout dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .i_elapsed_ms (i_elapsed_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_online     (o_online),
        .o_has_target (o_has_target),
        .o_target_x   (o_target_x),
        .o_target_y   (o_target_y),
        .o_age_ms     (o_age_ms),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.take_item(i_kind, i_rx_byte, i_elapsed_ms);
            end
            if (o_out_valid && i_out_ready) begin
                got.event_res = o_event_res;
                got.online = o_online;
                got.has_target = o_has_target;
                got.target_x = o_target_x;
                got.target_y = o_target_y;
                got.age_ms = o_age_ms;
                sb.check_status(got);
            end
        end
    end

    // receiver side, with an occasional long hold-off
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(logic kind, logic [BYTE_W-1:0] b, logic [DATA_W-1:0] ms);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_rx_byte <= b;
        i_elapsed_ms <= ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_bytes(bit [BYTE_W-1:0] q[$]);
        foreach (q[i]) send_item(1'b0, q[i], DATA_W'($urandom_range(65535)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(1'b0, s[i], DATA_W'($urandom_range(65535)));
        end
    endtask

    task automatic send_tick(logic [DATA_W-1:0] ms);
        send_item(1'b1, BYTE_W'($urandom_range(255)), ms);
    endtask

    function automatic void put_text(ref bit [BYTE_W-1:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    // "$1,5," then zeros then "7": 26 zeros fill the body exactly
    task automatic send_long(int zeros, bit close);
        bit [BYTE_W-1:0] q[$];
        put_text(q, "$1,5,");
        repeat (zeros) q.push_back(CH_ZERO);
        q.push_back(CH_ZERO + 8'd7);
        if (close) q.push_back(CH_HASH);
        send_bytes(q);
    endtask

    function automatic string num_text(int unsigned lim);
        case ($urandom_range(9))
            0: return "";
            1: return "0";
            2: return $sformatf("%0d", lim);
            3: return $sformatf("%0d", lim + 1);
            4: return {"0", $sformatf("%0d", $urandom_range(0, lim))};
            default: return $sformatf("%0d", $urandom_range(0, lim));
        endcase
    endfunction

    task automatic send_random_frame();
        bit [BYTE_W-1:0] q[$];
        string st;
        string xs;
        string ys;
        int unsigned mut;
        case ($urandom_range(11))
            0: st = "";
            1: st = $sformatf("%0d", $urandom_range(2, 9));
            2: st = "01";
            default: st = $urandom_range(1) ? "1" : "0";
        endcase
        if (st == "0" && $urandom_range(3) != 0) begin
            xs = "0";
            ys = "0";
        end else begin
            xs = num_text(sb.x_max);
            ys = num_text(sb.y_max);
        end
        put_text(q, {"$", st, ",", xs, ",", ys});
        mut = $urandom_range(19);
        case (mut)
            0: q.insert($urandom_range(1, q.size()),
                        BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
            1: q.insert($urandom_range(1, q.size()), BYTE_W'($urandom_range(255)));
            2: put_text(q, ",7");
            default: ;
        endcase
        // a missing end mark lets the next dollar sign restart the frame
        if (mut != 3) q.push_back(CH_HASH);
        send_bytes(q);
    endtask

    task automatic send_noise();
        bit [BYTE_W-1:0] q[$];
        repeat ($urandom_range(1, 6)) q.push_back(BYTE_W'($urandom_range(255)));
        send_bytes(q);
    endtask

    task automatic random_burst(int n);
        int goal;
        int unsigned pick;
        goal = items_sent + n;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                send_tick(DATA_W'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                        : $urandom_range(40)));
            end else if (pick < 24) begin
                send_long($urandom_range(20, 32), 1'b1);
            end else if (pick < 88) begin
                send_random_frame();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs(logic [DATA_W-1:0] t, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_TIMEOUT;
        i_cfg_data <= t;
        sb.set_reg(REG_TIMEOUT, t);
        @(posedge i_clk);
        i_cfg_idx <= REG_X_MAX;
        i_cfg_data <= x;
        sb.set_reg(REG_X_MAX, x);
        @(posedge i_clk);
        i_cfg_idx <= REG_Y_MAX;
        i_cfg_data <= y;
        sb.set_reg(REG_Y_MAX, y);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= 1'b0;
        i_rx_byte <= '0;
        i_elapsed_ms <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_TIMEOUT;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        send_tick(16'd5);
        send_text("$1,320,240#");
        send_tick(16'd0);
        send_tick(16'd100);
        send_tick(16'd1);
        send_text("$0,0,0#");
        send_text("ab,1#");
        send_text("$#");
        send_text("$,1,2#");
        send_text("$2,1,1#");
        send_text("$1,640,1#");
        send_text("$1,,5#");
        send_text("$1,5,480#");
        send_text("$1,5,#");
        send_text("$1,5#");
        send_text("$1,5,6,7#");
        send_text("$0,1,0#");
        send_text("$1~");
        send_text("$1, 2,3#");
        send_text("$1,999,1,#");
        send_text("$1,3$1,639,479#");
        send_text("$1,2");
        send_item(1'b0, 8'h1F, 16'hFFFF);
        send_text("$");
        send_item(1'b0, 8'h7F, 16'h0000);
        send_text("$1");
        send_item(1'b0, 8'h80, 16'hAAAA);
        send_item(1'b0, 8'hFF, 16'h5555);
        send_text("$1,");
        send_item(1'b0, 8'h00, 16'h0000);
        send_long(26, 1'b1);
        send_long(27, 1'b1);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        drain();

        // lowest register values
        load_regs(16'd0, 16'd0, 16'd0);
        send_text("$1,0,0#");
        send_tick(16'd0);
        send_tick(16'd1);
        send_text("$1,1,0#");
        send_text("$1,0,1#");
        send_text("$0,0,0#");
        drain();

        // highest register values
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_text("$1,65535,65535#");
        send_text("$1,65536,0#");
        send_text("$1,0,99999#");
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        drain();

        load_regs(TIMEOUT_RST, X_MAX_RST, Y_MAX_RST);

        // no idling
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_burst(100);
        drain();

        load_regs(DATA_W'($urandom_range(30)), DATA_W'($urandom_range(15)), 16'hFFFF);
        send_idle_pct = 49;
        recv_stall_pct = 0;
        random_burst(100);
        drain();

        // long receiver hold-off with the sender busy
        load_regs(16'hFFFF, DATA_W'($urandom_range(65535)), DATA_W'($urandom_range(9)));
        send_idle_pct = 0;
        recv_stall_pct = 49;
        hold_left = 300;
        random_burst(100);
        drain();

        load_regs(DATA_W'($urandom_range(50, 500)), DATA_W'($urandom_range(100, 1000)),
                  DATA_W'($urandom_range(100, 1000)));
        send_idle_pct = 13;
        recv_stall_pct = 13;
        random_burst(100);
        drain();

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
